// File: hdl/msxf_pkg.sv
// ----------------------------------------------------------------------------
// msxf_pkg
// Shared types, geometry constants and wrap tables for the sprite framebuffer.
// ----------------------------------------------------------------------------
package msxf_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int COL_W = $clog2(SCREEN_WIDTH);

  // sprite byte width in pixels
  localparam int SPRITE_W = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_DRAW  = 2'd3
  } cmd_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture request, launch row read
    logic exec;   // row data back: update row, produce result
  } ctl_t;

  typedef logic [ROW_W-1:0] row_tbl_t [256];
  typedef logic [COL_W-1:0] col_tbl_t [256];

  function automatic row_tbl_t build_row_tbl();
    row_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ROW_W'(i % SCREEN_HEIGHT);
    end
    return t;
  endfunction

  function automatic col_tbl_t build_col_tbl();
    col_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = COL_W'(i % SCREEN_WIDTH);
    end
    return t;
  endfunction

  // coordinate modulo screen size, indexed by the 8-bit coordinate
  localparam row_tbl_t ROW_MOD_TBL = build_row_tbl();
  localparam col_tbl_t COL_MOD_TBL = build_col_tbl();

endpackage

// File: hdl/msxf_ram.sv
// ----------------------------------------------------------------------------
// msxf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msxf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/msxf_ctrl.sv
// ----------------------------------------------------------------------------
// msxf_ctrl
// Two-state sequencer: take a request, then run the row update and result.
// ----------------------------------------------------------------------------
module msxf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output msxf_pkg::ctl_t   ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign ctl.load  = start && (state_r == ST_IDLE);
  assign ctl.exec  = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;

endmodule

// File: hdl/msxf_dp.sv
// ----------------------------------------------------------------------------
// msxf_dp
// Row store, per-row valid bits, sprite state and the row update logic.
// ----------------------------------------------------------------------------
module msxf_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msxf_pkg::ctl_t        ctl,
  input  logic [1:0]            in_cmd,
  input  logic [7:0]            in_pos_row,
  input  logic [7:0]            in_pos_col,
  input  logic [7:0]            in_sprite_byte,
  input  logic                  in_last_byte,
  output logic                  out_pixel_value,
  output logic                  out_collision,
  output logic                  out_bad_coord,
  output logic                  out_sprite_done
);

  localparam int H  = msxf_pkg::SCREEN_HEIGHT;
  localparam int W  = msxf_pkg::SCREEN_WIDTH;
  localparam int RW = msxf_pkg::ROW_W;
  localparam int CW = msxf_pkg::COL_W;
  localparam int SW = msxf_pkg::SPRITE_W;

  // captured request
  msxf_pkg::cmd_t  cmd_r;
  logic [RW-1:0]   row_r;
  logic [CW-1:0]   col_r;
  logic [SW-1:0]   byte_r;
  logic            last_r;
  logic            bad_r;
  logic            vld_r;

  // control state
  logic [H-1:0]    valid_r, valid_nxt;
  logic [7:0]      row_offset_r, row_offset_nxt;
  logic [RW-1:0]   off_mod_r, off_mod_nxt;
  logic            coll_seen_r, coll_seen_nxt;

  // result registers
  logic            pix_r, coll_r, bad_o_r, done_r;
  logic            pix_nxt, coll_nxt, done_nxt;

  // load-side signals
  msxf_pkg::cmd_t  cmd_in;
  logic [RW-1:0]   row_mod;
  logic [RW:0]     row_sum;
  logic [RW-1:0]   row_addr;
  logic            on_screen;
  logic            bad_in;

  // exec-side signals
  logic [W-1:0]    rd_data;
  logic [W-1:0]    row_data;
  logic [W-1:0]    draw_mask;
  logic [W-1:0]    wdata;
  logic            wr_en;
  logic            hit;
  logic [CW:0]     col_sum [SW];

  assign cmd_in    = msxf_pkg::cmd_t'(in_cmd);
  assign row_mod   = msxf_pkg::ROW_MOD_TBL[in_pos_row];
  assign on_screen = (in_pos_row < 8'(H)) && (in_pos_col < 8'(W));
  assign bad_in    = ((cmd_in == msxf_pkg::CMD_SET) || (cmd_in == msxf_pkg::CMD_READ))
                     && !on_screen;

  // sprite row: base row plus offset, both already below the height
  always_comb begin
    row_sum = {1'b0, row_mod} + {1'b0, off_mod_r};
    if (row_sum >= (RW+1)'(H)) begin
      row_sum = row_sum - (RW+1)'(H);
    end
    row_addr = (cmd_in == msxf_pkg::CMD_DRAW) ? row_sum[RW-1:0] : row_mod;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cmd_in;
      row_r  <= row_addr;
      col_r  <= msxf_pkg::COL_MOD_TBL[in_pos_col];
      byte_r <= in_sprite_byte;
      last_r <= in_last_byte;
      bad_r  <= bad_in;
      vld_r  <= valid_r[row_addr];
    end
  end

  msxf_ram #(
    .WIDTH (W),
    .DEPTH (H)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (row_r),
    .wdata (wdata),
    .re    (ctl.load),
    .raddr (row_addr),
    .rdata (rd_data)
  );

  // a row never written since the last clear reads as blank
  assign row_data = vld_r ? rd_data : '0;

  always_comb begin
    draw_mask = '0;
    for (int k = 0; k < SW; k++) begin
      col_sum[k] = {1'b0, col_r} + (CW+1)'(k);
      if (col_sum[k] >= (CW+1)'(W)) begin
        col_sum[k] = col_sum[k] - (CW+1)'(W);
      end
      if (byte_r[SW-1-k]) begin
        draw_mask[col_sum[k][CW-1:0]] = 1'b1;
      end
    end
  end

  assign hit = |(row_data & draw_mask);

  always_comb begin
    wr_en          = 1'b0;
    wdata          = row_data;
    valid_nxt      = valid_r;
    row_offset_nxt = row_offset_r;
    off_mod_nxt    = off_mod_r;
    coll_seen_nxt  = coll_seen_r;
    pix_nxt        = 1'b0;
    coll_nxt       = 1'b0;
    done_nxt       = 1'b0;
    if (ctl.exec) begin
      unique case (cmd_r)
        msxf_pkg::CMD_CLEAR: begin
          valid_nxt = '0;
        end
        msxf_pkg::CMD_SET: begin
          wr_en = !bad_r;
          wdata = row_data | (W'(1) << col_r);
        end
        msxf_pkg::CMD_READ: begin
          pix_nxt = !bad_r && row_data[col_r];
        end
        msxf_pkg::CMD_DRAW: begin
          wr_en          = 1'b1;
          wdata          = row_data ^ draw_mask;
          coll_seen_nxt  = coll_seen_r | hit;
          row_offset_nxt = row_offset_r + 8'd1;
          // offset modulo height; a wrap of the 8-bit offset lands on zero
          if (row_offset_r == 8'hFF || off_mod_r == RW'(H - 1)) begin
            off_mod_nxt = '0;
          end else begin
            off_mod_nxt = off_mod_r + RW'(1);
          end
          if (last_r) begin
            coll_nxt       = coll_seen_nxt;
            done_nxt       = 1'b1;
            row_offset_nxt = '0;
            off_mod_nxt    = '0;
            coll_seen_nxt  = 1'b0;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
      if (wr_en) begin
        valid_nxt[row_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      row_offset_r <= '0;
      off_mod_r    <= '0;
      coll_seen_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      row_offset_r <= row_offset_nxt;
      off_mod_r    <= off_mod_nxt;
      coll_seen_r  <= coll_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      pix_r   <= pix_nxt;
      coll_r  <= coll_nxt;
      bad_o_r <= bad_r;
      done_r  <= done_nxt;
    end
  end

  assign out_pixel_value = pix_r;
  assign out_collision   = coll_r;
  assign out_bad_coord   = bad_o_r;
  assign out_sprite_done = done_r;

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec && cmd_r == msxf_pkg::CMD_DRAW && last_r |=>
      row_offset_r == '0 && off_mod_r == '0 && !coll_seen_r)
    else $error("sprite state not cleared after last byte");

  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec && bad_r |-> !wr_en)
    else $error("row written on an off-screen request");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec && cmd_r == msxf_pkg::CMD_CLEAR |=> valid_r == '0)
    else $error("rows left valid after clear");

  a_off_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> {1'b0, off_mod_r} < (RW+1)'(H))
    else $error("row offset residue out of range");
`endif

endmodule

// File: hdl/monochrome_sprite_xor_framebuffer.sv
// ----------------------------------------------------------------------------
// monochrome_sprite_xor_framebuffer
// One-bit-per-pixel screen with clear, set, read and sprite-byte XOR draw.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// one result, shown with out_valid high for exactly one cycle; the receiver
// cannot hold it off. Every command passes through the exec state, where busy
// is high and no new request is taken, set by the read-modify-write of a
// screen row through the row memory's registered read port. Clear takes no
// longer than the other commands: per-row valid bits blank the whole screen
// at once, so no clearing pass follows reset or a clear command.
module monochrome_sprite_xor_framebuffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_pos_row,
  input  logic [7:0] in_pos_col,
  input  logic [7:0] in_sprite_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  output logic       out_pixel_value,
  output logic       out_collision,
  output logic       out_bad_coord,
  output logic       out_sprite_done
);

  msxf_pkg::ctl_t ctl;

  msxf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  msxf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_cmd          (in_cmd),
    .in_pos_row      (in_pos_row),
    .in_pos_col      (in_pos_col),
    .in_sprite_byte  (in_sprite_byte),
    .in_last_byte    (in_last_byte),
    .out_pixel_value (out_pixel_value),
    .out_collision   (out_collision),
    .out_bad_coord   (out_bad_coord),
    .out_sprite_done (out_sprite_done)
  );

endmodule
